@@ rtl/sdtq_pkg.sv @@
// Shared types, codes and constants for the sorted deadline timer queue.
package sdtq_pkg;

	localparam int TimersDefault = 16;
	localparam int TimeW         = 48;
	localparam int IdW           = 4;
	localparam int NumIds        = 16;
	localparam int RoundHalf     = 500;
	localparam int MsPerSec      = 1000;
	localparam logic [TimeW-1:0] TimeMax = '1;

	// Operation codes
	localparam logic [1:0] FUNC_ADD_MS  = 2'd0;
	localparam logic [1:0] FUNC_ADD_SEC = 2'd1;
	localparam logic [1:0] FUNC_CANCEL  = 2'd2;
	localparam logic [1:0] FUNC_ADVANCE = 2'd3;

	// Result status codes
	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_NEG     = 3'd1;
	localparam logic [2:0] STAT_ALREADY = 3'd2;
	localparam logic [2:0] STAT_NOTPEND = 3'd3;
	localparam logic [2:0] STAT_EXPIRED = 3'd4;
	localparam logic [2:0] STAT_NONE    = 3'd5;

	typedef struct packed {
		logic [1:0]        func;
		logic [IdW-1:0]    timer_id;
		logic signed [31:0] timeout;
		logic [TimeW-1:0]  new_time;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [IdW-1:0]   result_id;
		logic [TimeW-1:0] remaining;
		logic [TimeW-1:0] first_deadline;
		logic [4:0]       pending_count;
		logic             last;
	} rsp_t;

	typedef struct packed {
		logic [TimeW-1:0] deadline;
		logic [IdW-1:0]   owner;
	} entry_t;

endpackage

@@ rtl/sdtq_sec_div.sv @@
// Divide of the rounded current time by one thousand, one 13-bit digit per cycle.
module sdtq_sec_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [48:0] dividend,
	output logic        done,
	output logic [39:0] quotient
);

	// ceil(2^33 / 1000): exact for every partial dividend below 2^23
	localparam logic [23:0] Recip = 24'd8589935;

	logic [51:0] dvd_q;
	logic [39:0] quo_q;
	logic [9:0]  rem_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [22:0] num;
	logic [46:0] prod;
	logic [12:0] qd;
	logic [22:0] rem_full;

	// Divide the remainder and the next digit by reciprocal multiplication
	always_comb begin
		num      = {rem_q, dvd_q[51:39]};
		prod     = 47'(num) * 47'(Recip);
		qd       = prod[45:33];
		rem_full = num - 23'(qd) * 23'(sdtq_pkg::MsPerSec);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {3'b000, dividend};
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[38:0], 13'd0};
			rem_q <= rem_full[9:0];
			quo_q <= {quo_q[26:0], qd};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/sorted_deadline_timer_queue.sv @@
// Sorted deadline timer queue: pending one-shot timers held in deadline order in one
// synchronous memory (one read, one write a cycle). An add scans from the tail and
// shifts later entries up; a cancel searches from the head and then closes the gap
// by moving the entries behind it down. Each expired timer costs a head removal
// that moves the remaining entries down; an add in seconds first runs the divide by
// 1000. Every operation ends by reading the head entry to report the first deadline,
// and each result item is held until it is taken.
module sorted_deadline_timer_queue #(
	parameter int TIMERS = sdtq_pkg::TimersDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  sdtq_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output sdtq_pkg::rsp_t   rsp
);

	localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int CW = $clog2(TIMERS + 1);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DIV_GO   = 4'd1;
	localparam logic [3:0] S_DIV      = 4'd2;
	localparam logic [3:0] S_INS_RD   = 4'd3;
	localparam logic [3:0] S_INS_CHK  = 4'd4;
	localparam logic [3:0] S_SRCH_RD  = 4'd5;
	localparam logic [3:0] S_SRCH_CHK = 4'd6;
	localparam logic [3:0] S_SHF_RD   = 4'd7;
	localparam logic [3:0] S_SHF_WR   = 4'd8;
	localparam logic [3:0] S_HEAD_RD  = 4'd9;
	localparam logic [3:0] S_HEAD_WT  = 4'd10;
	localparam logic [3:0] S_OUT      = 4'd11;

	logic [3:0]                    state_q;
	logic [sdtq_pkg::TimeW-1:0]    cur_q;
	logic [CW-1:0]                 occ_q;
	logic [sdtq_pkg::NumIds-1:0]   flags_q;
	logic [CW-1:0]                 j_q;
	sdtq_pkg::req_t                req_q;
	logic [sdtq_pkg::TimeW-1:0]    when_q;
	logic [sdtq_pkg::IdW-1:0]      clr_q;
	logic [sdtq_pkg::IdW-1:0]      hd_owner_q;
	logic                          popped_q;
	logic [2:0]                    status_q;
	logic [sdtq_pkg::IdW-1:0]      id_q;
	logic [sdtq_pkg::TimeW-1:0]    rem_q;
	logic [sdtq_pkg::TimeW-1:0]    fd_q;
	logic                          last_q;

	sdtq_pkg::entry_t mem_q [TIMERS];
	sdtq_pkg::entry_t rd_q;
	logic             rd_en;
	logic [IW-1:0]    rd_addr;
	logic             wr_en;
	logic [IW-1:0]    wr_addr;
	sdtq_pkg::entry_t wr_data;

	logic        div_done;
	logic [39:0] div_quot;
	logic [48:0] ms_sum;
	logic [40:0] sec_sum;
	logic [51:0] sec_prod;
	logic        req_neg;
	logic        req_vid;
	logic        req_pend;
	logic        head_exp;
	logic [CW-1:0] j_inc;
	logic [CW-1:0] j_dec;

	// Divide the rounded time for whole-second adds
	sdtq_sec_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DIV_GO),
		.dividend (49'(cur_q) + 49'(sdtq_pkg::RoundHalf)),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Deadline arithmetic and request checks
	always_comb begin
		ms_sum   = 49'(cur_q) + 49'(req.timeout[30:0]);
		sec_sum  = 41'(div_quot) + 41'(req_q.timeout[30:0]);
		sec_prod = (52'(sec_sum) << 10) - (52'(sec_sum) << 4) - (52'(sec_sum) << 3);
		req_neg  = req.timeout[31];
		req_vid  = int'(req.timer_id) < TIMERS;
		req_pend = req_vid && flags_q[req.timer_id];
		head_exp = (occ_q != '0) && (rd_q.deadline <= cur_q);
		j_inc    = CW'(j_q + 1'b1);
		j_dec    = CW'(j_q - 1'b1);
	end

	// Drive memory ports per state
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = j_q[IW-1:0];
		wr_data = rd_q;
		case (state_q)
			S_INS_RD: begin
				if (j_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = j_dec[IW-1:0];
				end else begin
					wr_en   = 1'b1;
					wr_data = '{deadline: when_q, owner: req_q.timer_id};
				end
			end
			S_INS_CHK: begin
				wr_en = 1'b1;
				if (rd_q.deadline <= when_q) begin
					wr_data = '{deadline: when_q, owner: req_q.timer_id};
				end
			end
			S_SRCH_RD: begin
				rd_en   = (j_q != occ_q);
				rd_addr = j_q[IW-1:0];
			end
			S_SHF_RD: begin
				rd_en   = (j_inc < occ_q);
				rd_addr = j_inc[IW-1:0];
			end
			S_SHF_WR: begin
				wr_en = 1'b1;
			end
			S_HEAD_RD: begin
				rd_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Queue memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cur_q    <= '0;
			occ_q    <= '0;
			flags_q  <= '0;
			popped_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						popped_q <= 1'b0;
						case (req.func)
							sdtq_pkg::FUNC_ADD_MS, sdtq_pkg::FUNC_ADD_SEC: begin
								if (req_neg || !req_vid || req_pend) begin
									state_q <= S_HEAD_RD;
								end else if (req.func == sdtq_pkg::FUNC_ADD_MS) begin
									state_q <= S_INS_RD;
								end else begin
									state_q <= S_DIV_GO;
								end
							end
							sdtq_pkg::FUNC_CANCEL: begin
								state_q <= req_pend ? S_SRCH_RD : S_HEAD_RD;
							end
							default: begin
								cur_q   <= req.new_time;
								state_q <= S_HEAD_RD;
							end
						endcase
					end
				end
				S_DIV_GO: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_INS_RD;
					end
				end
				S_INS_RD: begin
					if (j_q != '0) begin
						state_q <= S_INS_CHK;
					end else begin
						occ_q                     <= CW'(occ_q + 1'b1);
						flags_q[req_q.timer_id]   <= 1'b1;
						state_q                   <= S_HEAD_RD;
					end
				end
				S_INS_CHK: begin
					if (rd_q.deadline > when_q) begin
						state_q <= S_INS_RD;
					end else begin
						occ_q                   <= CW'(occ_q + 1'b1);
						flags_q[req_q.timer_id] <= 1'b1;
						state_q                 <= S_HEAD_RD;
					end
				end
				S_SRCH_RD: begin
					if (j_q == occ_q) begin
						flags_q[req_q.timer_id] <= 1'b0;
						state_q                 <= S_HEAD_RD;
					end else begin
						state_q <= S_SRCH_CHK;
					end
				end
				S_SRCH_CHK: begin
					state_q <= (rd_q.owner == req_q.timer_id) ? S_SHF_RD : S_SRCH_RD;
				end
				S_SHF_RD: begin
					if (j_inc < occ_q) begin
						state_q <= S_SHF_WR;
					end else begin
						occ_q          <= CW'(occ_q - 1'b1);
						flags_q[clr_q] <= 1'b0;
						state_q        <= S_HEAD_RD;
					end
				end
				S_SHF_WR: state_q <= S_SHF_RD;
				S_HEAD_RD: state_q <= S_HEAD_WT;
				S_HEAD_WT: begin
					if (req_q.func == sdtq_pkg::FUNC_ADVANCE && !popped_q && head_exp) begin
						popped_q <= 1'b1;
						state_q  <= S_SHF_RD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (rsp_ready) begin
						state_q <= last_q ? S_IDLE : S_SHF_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q  <= req;
				id_q   <= req.timer_id;
				rem_q  <= '0;
				j_q    <= (req.func == sdtq_pkg::FUNC_CANCEL) ? '0 : occ_q;
				clr_q  <= req.timer_id;
				if (req.func == sdtq_pkg::FUNC_CANCEL) begin
					status_q <= req_pend ? sdtq_pkg::STAT_OK : sdtq_pkg::STAT_NOTPEND;
				end else if (req_neg) begin
					status_q <= sdtq_pkg::STAT_NEG;
				end else if (!req_vid) begin
					status_q <= sdtq_pkg::STAT_NOTPEND;
				end else begin
					status_q <= req_pend ? sdtq_pkg::STAT_ALREADY : sdtq_pkg::STAT_OK;
				end
			end
			S_DIV: begin
				if (div_done) begin
					when_q <= (sec_prod > 52'(sdtq_pkg::TimeMax)) ?
						sdtq_pkg::TimeMax : sec_prod[sdtq_pkg::TimeW-1:0];
				end
			end
			S_INS_CHK: begin
				if (rd_q.deadline > when_q) begin
					j_q <= j_dec;
				end
			end
			S_SRCH_RD: begin
				if (j_q == occ_q) begin
					status_q <= sdtq_pkg::STAT_NOTPEND;
				end
			end
			S_SRCH_CHK: begin
				if (rd_q.owner == req_q.timer_id) begin
					rem_q <= (rd_q.deadline < cur_q) ? '0 : rd_q.deadline - cur_q;
				end else begin
					j_q <= j_inc;
				end
			end
			S_SHF_WR: j_q <= j_inc;
			S_HEAD_WT: begin
				fd_q       <= (occ_q != '0) ? rd_q.deadline : '0;
				hd_owner_q <= rd_q.owner;
				last_q     <= 1'b1;
				if (req_q.func == sdtq_pkg::FUNC_ADVANCE) begin
					if (!popped_q) begin
						clr_q    <= rd_q.owner;
						j_q      <= '0;
						status_q <= sdtq_pkg::STAT_NONE;
						id_q     <= '0;
					end else begin
						status_q <= sdtq_pkg::STAT_EXPIRED;
						id_q     <= clr_q;
						last_q   <= !head_exp;
					end
				end
			end
			S_OUT: begin
				if (rsp_ready && !last_q) begin
					clr_q <= hd_owner_q;
					j_q   <= '0;
				end
			end
			default: begin
				j_q <= j_q;
			end
		endcase
		// Load the ms deadline in every idle cycle, so it is ready when an add is accepted
		if (state_q == S_IDLE) begin
			when_q <= (ms_sum > 49'(sdtq_pkg::TimeMax)) ?
				sdtq_pkg::TimeMax : ms_sum[sdtq_pkg::TimeW-1:0];
		end
	end

	// Handshake and payload
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_OUT);
	always_comb begin
		rsp.status         = status_q;
		rsp.result_id      = id_q;
		rsp.remaining      = rem_q;
		rsp.first_deadline = fd_q;
		rsp.pending_count  = 5'(occ_q);
		rsp.last           = last_q;
	end

	// Checks
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(TIMERS))
		else $error("queue fill beyond depth");
	a_flags_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> $countones(flags_q) == int'(occ_q))
		else $error("pending flags disagree with fill");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("item taken while result shown");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && last_q |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle");

endmodule

@@ bench/sorted_deadline_timer_queue_test.sv @@
// Self-checking test of the sorted deadline timer queue with an item-level predictor.
module sorted_deadline_timer_queue_test;

	// Predictor of the timer queue plus the list of result items still owed
	class timer_scoreboard;
		logic [sdtq_pkg::TimeW-1:0] q_deadline[$];
		logic [sdtq_pkg::IdW-1:0]   q_owner[$];
		logic [sdtq_pkg::NumIds-1:0] pend;
		logic [sdtq_pkg::TimeW-1:0] now;
		sdtq_pkg::rsp_t owed[$];
		int errors;

		function new();
			pend = '0;
			now = '0;
			errors = 0;
		endfunction

		function void push_rsp(logic [2:0] st, logic [sdtq_pkg::IdW-1:0] id,
				logic [sdtq_pkg::TimeW-1:0] rem, bit lst);
			sdtq_pkg::rsp_t r;
			r.status = st;
			r.result_id = id;
			r.remaining = rem;
			r.first_deadline = q_deadline.size() ? q_deadline[0] : '0;
			r.pending_count = 5'(q_deadline.size());
			r.last = lst;
			owed.push_back(r);
		endfunction

		// Predict the result items caused by one accepted request
		function void note_request(sdtq_pkg::req_t q);
			logic [63:0] w;
			int pos;
			int n;
			if (q.func == sdtq_pkg::FUNC_ADD_MS || q.func == sdtq_pkg::FUNC_ADD_SEC) begin
				if (q.timeout < 0) begin
					push_rsp(sdtq_pkg::STAT_NEG, q.timer_id, '0, 1);
				end else if (pend[q.timer_id]) begin
					push_rsp(sdtq_pkg::STAT_ALREADY, q.timer_id, '0, 1);
				end else begin
					if (q.func == sdtq_pkg::FUNC_ADD_MS)
						w = 64'(now) + 64'(unsigned'(q.timeout));
					else
						w = ((64'(now) + sdtq_pkg::RoundHalf) / sdtq_pkg::MsPerSec
							+ 64'(unsigned'(q.timeout))) * sdtq_pkg::MsPerSec;
					if (w > 64'(sdtq_pkg::TimeMax)) w = 64'(sdtq_pkg::TimeMax);
					pos = 0;
					while (pos < q_deadline.size() && q_deadline[pos] <= w[sdtq_pkg::TimeW-1:0])
						pos++;
					q_deadline.insert(pos, w[sdtq_pkg::TimeW-1:0]);
					q_owner.insert(pos, q.timer_id);
					pend[q.timer_id] = 1'b1;
					push_rsp(sdtq_pkg::STAT_OK, q.timer_id, '0, 1);
				end
			end else if (q.func == sdtq_pkg::FUNC_CANCEL) begin
				pos = 0;
				while (pos < q_owner.size() && q_owner[pos] != q.timer_id) pos++;
				if (!pend[q.timer_id] || pos >= q_owner.size()) begin
					pend[q.timer_id] = 1'b0;
					push_rsp(sdtq_pkg::STAT_NOTPEND, q.timer_id, '0, 1);
				end else begin
					w = (q_deadline[pos] < now) ? 64'd0 : 64'(q_deadline[pos] - now);
					q_deadline.delete(pos);
					q_owner.delete(pos);
					pend[q.timer_id] = 1'b0;
					push_rsp(sdtq_pkg::STAT_OK, q.timer_id, w[sdtq_pkg::TimeW-1:0], 1);
				end
			end else begin
				now = q.new_time;
				n = 0;
				while (q_deadline.size() > 0 && q_deadline[0] <= now) begin
					logic [sdtq_pkg::IdW-1:0] o;
					o = q_owner.pop_front();
					void'(q_deadline.pop_front());
					pend[o] = 1'b0;
					push_rsp(sdtq_pkg::STAT_EXPIRED, o, '0, 0);
					n++;
				end
				if (n == 0) push_rsp(sdtq_pkg::STAT_NONE, '0, '0, 1);
				else owed[$].last = 1'b1;
			end
		endfunction

		// Compare one result item with the oldest owed one
		task check_result(sdtq_pkg::rsp_t r);
			sdtq_pkg::rsp_t e;
			if (owed.size() == 0) begin
				report_mismatch("result item with nothing owed");
				return;
			end
			e = owed.pop_front();
			if (r.status !== e.status) report_mismatch($sformatf("status %0d exp %0d",
				r.status, e.status));
			if (r.result_id !== e.result_id) report_mismatch($sformatf("id %0d exp %0d",
				r.result_id, e.result_id));
			if (r.remaining !== e.remaining) report_mismatch($sformatf("remaining %0d exp %0d",
				r.remaining, e.remaining));
			if (r.first_deadline !== e.first_deadline) report_mismatch($sformatf(
				"first deadline %0d exp %0d", r.first_deadline, e.first_deadline));
			if (r.pending_count !== e.pending_count) report_mismatch($sformatf(
				"count %0d exp %0d", r.pending_count, e.pending_count));
			if (r.last !== e.last) report_mismatch($sformatf("last %0d exp %0d",
				r.last, e.last));
		endtask

		task report_mismatch(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	sdtq_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	sdtq_pkg::rsp_t rsp;

	int send_idle_pct = 29;
	int recv_idle_pct = 63;
	logic [sdtq_pkg::TimeW-1:0] stim_time = '0;
	timer_scoreboard sb = new();

	sorted_deadline_timer_queue uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: stall at random, check every accepted result item
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) sb.check_result(rsp);
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one request item and hold it until accepted
	task automatic send_item(logic [1:0] f, logic [sdtq_pkg::IdW-1:0] id, logic [31:0] tmo,
			logic [sdtq_pkg::TimeW-1:0] nt);
		sdtq_pkg::req_t q;
		q.func = f;
		q.timer_id = id;
		q.timeout = tmo;
		q.new_time = nt;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= q;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.note_request(q);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Random item, mostly well-formed adds and advances that keep time moving
	task automatic random_item();
		int k;
		logic [31:0] tmo;
		k = $urandom_range(99);
		if ($urandom_range(9) == 0) tmo = $urandom();
		else if ($urandom_range(3) == 0) tmo = $urandom_range(20);
		else tmo = $urandom_range(5000);
		if (k < 40) begin
			send_item(sdtq_pkg::FUNC_ADD_MS, 4'($urandom_range(15)), tmo, 48'($urandom()));
		end else if (k < 52) begin
			send_item(sdtq_pkg::FUNC_ADD_SEC, 4'($urandom_range(15)), tmo, 48'($urandom()));
		end else if (k < 70) begin
			send_item(sdtq_pkg::FUNC_CANCEL, 4'($urandom_range(15)), $urandom(),
				48'($urandom()));
		end else begin
			if ($urandom_range(19) == 0)
				stim_time = 48'({$urandom(), $urandom()});
			else if ($urandom_range(9) == 0)
				stim_time = stim_time - 48'($urandom_range(3000));
			else
				stim_time = stim_time + 48'($urandom_range(3000));
			send_item(sdtq_pkg::FUNC_ADVANCE, 4'($urandom_range(15)), $urandom(), stim_time);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every status, saturation and equal deadlines
		send_item(sdtq_pkg::FUNC_ADVANCE, 4'd0, 32'd0, 48'd0);
		send_item(sdtq_pkg::FUNC_ADD_MS, 4'd0, 32'h8000_0000, 48'd0);
		send_item(sdtq_pkg::FUNC_ADD_SEC, 4'd1, 32'hFFFF_FFFF, 48'd0);
		send_item(sdtq_pkg::FUNC_ADD_MS, 4'd0, 32'd100, 48'd0);
		send_item(sdtq_pkg::FUNC_ADD_MS, 4'd1, 32'd100, 48'd0);
		send_item(sdtq_pkg::FUNC_ADD_MS, 4'd0, 32'd5, 48'd0);
		send_item(sdtq_pkg::FUNC_ADD_MS, 4'd15, 32'h7FFF_FFFF, 48'd0);
		send_item(sdtq_pkg::FUNC_ADD_SEC, 4'd2, 32'd0, 48'd0);
		send_item(sdtq_pkg::FUNC_CANCEL, 4'd9, 32'd0, 48'd0);
		send_item(sdtq_pkg::FUNC_ADVANCE, 4'd0, 32'd0, 48'd1499);
		send_item(sdtq_pkg::FUNC_ADD_SEC, 4'd3, 32'd2, 48'd0);
		send_item(sdtq_pkg::FUNC_CANCEL, 4'd15, 32'd0, 48'd0);
		send_item(sdtq_pkg::FUNC_ADVANCE, 4'd0, 32'd0, 48'd1500);
		send_item(sdtq_pkg::FUNC_ADD_SEC, 4'd4, 32'd1, 48'd0);
		send_item(sdtq_pkg::FUNC_CANCEL, 4'd3, 32'd0, 48'd0);
		send_item(sdtq_pkg::FUNC_ADVANCE, 4'd0, 32'd0, 48'hFFFF_FFFF_FF00);
		send_item(sdtq_pkg::FUNC_ADD_MS, 4'd5, 32'h7FFF_FFFF, 48'd0);
		send_item(sdtq_pkg::FUNC_ADD_SEC, 4'd6, 32'h7FFF_FFFF, 48'd0);
		send_item(sdtq_pkg::FUNC_CANCEL, 4'd5, 32'd0, 48'd0);
		send_item(sdtq_pkg::FUNC_ADVANCE, 4'd0, 32'd0, 48'd10);
		send_item(sdtq_pkg::FUNC_CANCEL, 4'd6, 32'd0, 48'd0);
		send_item(sdtq_pkg::FUNC_ADVANCE, 4'd0, 32'd0, sdtq_pkg::TimeMax);
		// Fill all sixteen with one deadline, then expire them in one go
		stim_time = '0;
		send_item(sdtq_pkg::FUNC_ADVANCE, 4'd0, 32'd0, 48'd0);
		for (int i = 0; i < 16; i++) send_item(sdtq_pkg::FUNC_ADD_MS, i[3:0], 32'd7, 48'd0);
		drain_results();
		send_item(sdtq_pkg::FUNC_ADVANCE, 4'd0, 32'd0, 48'd7);

		// Random phases with changing idle pattern
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 29 : (p == 1) ? 63 : 0;
			recv_idle_pct = (p == 0) ? 63 : (p == 1) ? 29 : 0;
			for (int i = 0; i < 55; i++) random_item();
			drain_results();
		end
		// Negative-timeout adds to ids 15 down to 12 and cancels of ids 0 to 3
		for (int i = 0; i < 4; i++) begin
			send_item(sdtq_pkg::FUNC_ADD_MS, 4'hF ^ i[3:0], $urandom() | 32'h8000_0000,
				~48'd0);
			send_item(sdtq_pkg::FUNC_CANCEL, i[3:0], 32'h7FFF_FFFF, 48'hAAAA_AAAA_AAAA);
		end
		drain_results();

		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ sorted_deadline_timer_queue.f @@
rtl/sdtq_pkg.sv
rtl/sdtq_sec_div.sv
rtl/sorted_deadline_timer_queue.sv
bench/sorted_deadline_timer_queue_test.sv
